[src/pgku_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgku_pkg
// Types, constants and arithmetic helpers of the per-pixel gradient Kalman
// update pipeline.
// ----------------------------------------------------------------------------
package pgku_pkg;

	localparam int MAP_WIDTH  = 256;
	localparam int MAP_HEIGHT = 256;
	localparam int PIXELS     = MAP_WIDTH * MAP_HEIGHT;
	localparam int PIX_W      = $clog2(PIXELS);

	localparam int COORD_W   = 8;
	localparam int MEAS_W    = 24;
	localparam int MAG_W     = MEAS_W + 1;
	localparam int VEL_W     = 24;
	localparam int VAL_W     = 32;
	localparam int THR_W     = 23;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [VAL_W-1:0] NOISE_RST   = 32'd65536;
	localparam logic [VAL_W-1:0] INITVAR_RST = 32'd65536;
	localparam logic [THR_W-1:0] THR_RST     = 23'd2;

	localparam int H_W    = 44;
	localparam int SUM_W  = 57;
	localparam int QUO_W  = 32;
	localparam int NUM_W  = 60;
	localparam int DIV_W  = 56;
	localparam int DSH_W  = DIV_W + QUO_W - 1;
	localparam int NUM_LO = NUM_W - QUO_W;
	localparam int RG_W   = 50;
	localparam int RV_W   = 48;

	localparam int DIV_STAGES = QUO_W + 2;
	localparam int DIV_FIRST  = 7;
	localparam int NST        = DIV_FIRST + DIV_STAGES + 2;

	typedef enum logic {
		OP_CLEAR  = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MEAS_NOISE    = 2'd0,
		REG_INIT_VARIANCE = 2'd1,
		REG_MIN_MEAS      = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] gx;
		logic signed [VAL_W-1:0] gy;
		logic [VAL_W-1:0]        a;
		logic [VAL_W-1:0]        b;
		logic signed [VAL_W-1:0] c;
	} cell_t;

	typedef struct packed {
		op_t                     op;
		logic                    in_map;
		logic                    upd;
		cell_t                   est;
		logic signed [VAL_W-1:0] nu;
		logic signed [VAL_W-1:0] pvx;
		logic signed [VAL_W-1:0] pvy;
	} item_t;

	function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int k);
		return (x + (64'sd1 <<< (k - 1))) >>> k;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (x < -64'sd2147483648)
			return 32'sh80000000;
		else
			return x[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] satu32(input logic signed [63:0] x);
		if (x < 64'sd0)
			return '0;
		else if (x > 64'sd4294967295)
			return '1;
		else
			return x[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] abs32(input logic signed [VAL_W-1:0] v);
		return v[VAL_W-1] ? VAL_W'(-v) : v;
	endfunction

	function automatic logic signed [VAL_W-1:0] wsat(input logic [QUO_W-1:0] q,
			input logic ovf, input logic neg);
		if (neg) begin
			if (ovf || q > 32'h8000_0000)
				return 32'sh80000000;
			else
				return VAL_W'(-q);
		end else begin
			if (ovf || q[QUO_W-1])
				return 32'sh7fffffff;
			else
				return q;
		end
	endfunction

endpackage
`default_nettype wire

[src/pgku_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgku_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pgku_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]              rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

[src/pixel_gradient_kalman_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_gradient_kalman_update
// Per-pixel Kalman update of a two-element gradient estimate and its 2x2
// covariance over a 256 x 256 map. One transaction enters per clock when
// neither the output stall nor a pixel hazard holds the input. Most of the
// pipeline is a 34-stage radix-2 divider forming the two gains. All pixel
// state sits in one 65536 x 160 RAM with one read and one write port; a
// transaction whose pixel is still in flight is held at the input until the
// earlier one has written back, so transactions on the same pixel never
// overlap in the pipeline. No clearing pass follows reset: a pixel must
// be cleared before its first update.
// ----------------------------------------------------------------------------
module pixel_gradient_kalman_update (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [pgku_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pgku_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 op,
	input  wire logic [pgku_pkg::COORD_W-1:0]         pixel_x,
	input  wire logic [pgku_pkg::COORD_W-1:0]         pixel_y,
	input  wire logic signed [pgku_pkg::MEAS_W-1:0]   meas,
	input  wire logic signed [pgku_pkg::VEL_W-1:0]    vel_x,
	input  wire logic signed [pgku_pkg::VEL_W-1:0]    vel_y,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [pgku_pkg::VAL_W-1:0]         grad_x,
	output logic signed [pgku_pkg::VAL_W-1:0]         grad_y,
	output logic [pgku_pkg::VAL_W-1:0]                var_x,
	output logic [pgku_pkg::VAL_W-1:0]                var_y,
	output logic                                      applied
);

	logic [pgku_pkg::VAL_W-1:0] meas_noise_q;
	logic [pgku_pkg::VAL_W-1:0] init_var_q;
	logic [pgku_pkg::THR_W-1:0] min_meas_q;

	logic en, hazard, in_accept, in_map, ram_we;
	logic [pgku_pkg::PIX_W-1:0] in_addr;

	logic [pgku_pkg::NST:1]    tag_v_s;
	logic [pgku_pkg::PIX_W-1:0] tag_addr_s [1:pgku_pkg::NST];

	logic [$bits(pgku_pkg::cell_t)-1:0] ram_rd_data;
	pgku_pkg::cell_t cell_s1, cell_s2, cell_s3, cell_s4, cell_s5, cell_s6, cell_new;

	pgku_pkg::op_t op_s1, op_s2, op_s3, op_s4, op_s5, op_s6;
	logic in_map_s1, in_map_s2, in_map_s3, in_map_s4, in_map_s5, in_map_s6;
	logic big_s2, big_s3, big_s4, big_s5, big_s6;
	logic signed [pgku_pkg::MEAS_W-1:0] meas_s1, meas_s2, meas_s3, meas_s4;
	logic signed [pgku_pkg::VEL_W-1:0] vx_s1, vx_s2, vx_s3, vx_s4;
	logic signed [pgku_pkg::VEL_W-1:0] vy_s1, vy_s2, vy_s3, vy_s4;
	logic [pgku_pkg::MAG_W-1:0] mag_s1;

	logic signed [55:0] gxvx_s2, gyvy_s2, cvy_s2, cvx_s2;
	logic signed [56:0] avx_s2, bvy_s2;
	logic signed [56:0] hsum_s3;
	logic signed [57:0] pxsum_s3, pysum_s3;
	logic signed [pgku_pkg::H_W-1:0] h_s4;
	logic signed [pgku_pkg::VAL_W-1:0] pvx_s4, pvy_s4, pvx_s5, pvy_s5, pvx_s6, pvy_s6;
	logic signed [pgku_pkg::VAL_W-1:0] nu_s5, nu_s6;
	logic signed [55:0] sx_s5, sy_s5;
	logic signed [pgku_pkg::SUM_W-1:0] s_s6;

	pgku_pkg::item_t            dv_item_s [0:pgku_pkg::DIV_STAGES-1];
	logic [pgku_pkg::DIV_W-1:0] dv_d_s    [0:pgku_pkg::DIV_STAGES-1];
	logic [pgku_pkg::NUM_W-1:0] dv_rx_s   [0:pgku_pkg::DIV_STAGES-1];
	logic [pgku_pkg::NUM_W-1:0] dv_ry_s   [0:pgku_pkg::DIV_STAGES-1];
	logic [pgku_pkg::QUO_W-1:0] dv_qx_s   [0:pgku_pkg::DIV_STAGES-1];
	logic [pgku_pkg::QUO_W-1:0] dv_qy_s   [0:pgku_pkg::DIV_STAGES-1];
	logic [pgku_pkg::DIV_STAGES-1:0] dv_ox_s, dv_oy_s, dv_nx_s, dv_ny_s;
	logic [pgku_pkg::NUM_W-1:0] rx_n [0:pgku_pkg::DIV_STAGES-1];
	logic [pgku_pkg::NUM_W-1:0] ry_n [0:pgku_pkg::DIV_STAGES-1];
	logic [pgku_pkg::DIV_STAGES-1:0] gex_n, gey_n;

	pgku_pkg::item_t item_s41, item_s42, item_s43;
	logic signed [pgku_pkg::VAL_W-1:0] wx_s41, wy_s41;
	logic signed [63:0] wxnu_s42, wynu_s42, wxpx_s42, wypy_s42, wxpy_s42;
	logic signed [pgku_pkg::RG_W-1:0] rgx_s43, rgy_s43;
	logic signed [pgku_pkg::RV_W-1:0] rva_s43, rvb_s43, rvc_s43;

	logic out_v_q;
	logic signed [pgku_pkg::VAL_W-1:0] grad_x_q, grad_y_q;
	logic [pgku_pkg::VAL_W-1:0] var_x_q, var_y_q;
	logic applied_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_noise_q <= pgku_pkg::NOISE_RST;
			init_var_q   <= pgku_pkg::INITVAR_RST;
			min_meas_q   <= pgku_pkg::THR_RST;
		end else if (cfg_we) begin
			case (pgku_pkg::cfg_reg_t'(cfg_index))
				pgku_pkg::REG_MEAS_NOISE:    meas_noise_q <= cfg_data;
				pgku_pkg::REG_INIT_VARIANCE: init_var_q   <= cfg_data;
				pgku_pkg::REG_MIN_MEAS:      min_meas_q   <= cfg_data[pgku_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// input handshake and pixel hazard
	assign en        = !out_v_q || !out_stall;
	assign in_stall  = !en || hazard;
	assign in_accept = in_valid && !in_stall;
	assign in_map    = (32'(pixel_x) < pgku_pkg::MAP_WIDTH) &&
			(32'(pixel_y) < pgku_pkg::MAP_HEIGHT);
	assign in_addr   = pgku_pkg::PIX_W'(32'(pixel_y) * pgku_pkg::MAP_WIDTH + 32'(pixel_x));

	always_comb begin
		hazard = 1'b0;
		for (int k = 1; k <= pgku_pkg::NST; k++)
			if (tag_v_s[k] && tag_addr_s[k] == in_addr)
				hazard = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_v_s <= '0;
		else if (en)
			tag_v_s <= {tag_v_s[pgku_pkg::NST-1:1], in_accept};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_addr_s[1] <= in_addr;
			for (int k = 2; k <= pgku_pkg::NST; k++)
				tag_addr_s[k] <= tag_addr_s[k-1];
		end
	end

	pgku_ram #(
		.WIDTH($bits(pgku_pkg::cell_t)),
		.DEPTH(pgku_pkg::PIXELS)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(tag_addr_s[pgku_pkg::NST]),
		.wr_data(cell_new),
		.rd_en  (en),
		.rd_addr(in_addr),
		.rd_data(ram_rd_data)
	);

	assign cell_s1 = pgku_pkg::cell_t'(ram_rd_data);
	assign mag_s1  = meas_s1[pgku_pkg::MEAS_W-1] ?
			pgku_pkg::MAG_W'(-pgku_pkg::MAG_W'(meas_s1)) : pgku_pkg::MAG_W'(meas_s1);

	// stages 1 to 6: projections, innovation and its variance
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1     <= pgku_pkg::op_t'(op);
			in_map_s1 <= in_map;
			meas_s1   <= meas;
			vx_s1     <= vel_x;
			vy_s1     <= vel_y;

			op_s2     <= op_s1;
			in_map_s2 <= in_map_s1;
			cell_s2   <= cell_s1;
			meas_s2   <= meas_s1;
			vx_s2     <= vx_s1;
			vy_s2     <= vy_s1;
			big_s2    <= mag_s1 >= pgku_pkg::MAG_W'(min_meas_q);
			gxvx_s2   <= $signed(cell_s1.gx) * vx_s1;
			gyvy_s2   <= $signed(cell_s1.gy) * vy_s1;
			avx_s2    <= $signed({1'b0, cell_s1.a}) * vx_s1;
			cvy_s2    <= $signed(cell_s1.c) * vy_s1;
			cvx_s2    <= $signed(cell_s1.c) * vx_s1;
			bvy_s2    <= $signed({1'b0, cell_s1.b}) * vy_s1;

			op_s3     <= op_s2;
			in_map_s3 <= in_map_s2;
			cell_s3   <= cell_s2;
			meas_s3   <= meas_s2;
			vx_s3     <= vx_s2;
			vy_s3     <= vy_s2;
			big_s3    <= big_s2;
			hsum_s3   <= 57'(gxvx_s2) + 57'(gyvy_s2);
			pxsum_s3  <= 58'(avx_s2) + 58'(cvy_s2);
			pysum_s3  <= 58'(cvx_s2) + 58'(bvy_s2);

			op_s4     <= op_s3;
			in_map_s4 <= in_map_s3;
			cell_s4   <= cell_s3;
			meas_s4   <= meas_s3;
			vx_s4     <= vx_s3;
			vy_s4     <= vy_s3;
			big_s4    <= big_s3;
			h_s4      <= pgku_pkg::H_W'(pgku_pkg::rnd(64'(hsum_s3), 14));
			pvx_s4    <= pgku_pkg::sat32(pgku_pkg::rnd(64'(pxsum_s3), 12));
			pvy_s4    <= pgku_pkg::sat32(pgku_pkg::rnd(64'(pysum_s3), 12));

			op_s5     <= op_s4;
			in_map_s5 <= in_map_s4;
			cell_s5   <= cell_s4;
			big_s5    <= big_s4;
			pvx_s5    <= pvx_s4;
			pvy_s5    <= pvy_s4;
			sx_s5     <= vx_s4 * pvx_s4;
			sy_s5     <= vy_s4 * pvy_s4;
			nu_s5     <= pgku_pkg::sat32(64'(meas_s4) - 64'(h_s4));

			op_s6     <= op_s5;
			in_map_s6 <= in_map_s5;
			cell_s6   <= cell_s5;
			big_s6    <= big_s5;
			pvx_s6    <= pvx_s5;
			pvy_s6    <= pvy_s5;
			nu_s6     <= nu_s5;
			s_s6      <= pgku_pkg::SUM_W'(sx_s5) + pgku_pkg::SUM_W'(sy_s5) +
					$signed({13'b0, meas_noise_q, 12'b0});
		end
	end

	// gain divider: setup, overflow check, then one quotient bit per stage
	always_comb begin
		logic [pgku_pkg::DSH_W-1:0] sh;
		for (int j = 0; j < pgku_pkg::DIV_STAGES; j++) begin
			rx_n[j]  = '0;
			ry_n[j]  = '0;
			gex_n[j] = 1'b0;
			gey_n[j] = 1'b0;
		end
		for (int j = 2; j < pgku_pkg::DIV_STAGES; j++) begin
			sh = pgku_pkg::DSH_W'(dv_d_s[j-1]) << (pgku_pkg::DIV_STAGES - 1 - j);
			gex_n[j] = (sh[pgku_pkg::DSH_W-1:pgku_pkg::NUM_W] == '0) &&
					(dv_rx_s[j-1] >= sh[pgku_pkg::NUM_W-1:0]);
			gey_n[j] = (sh[pgku_pkg::DSH_W-1:pgku_pkg::NUM_W] == '0) &&
					(dv_ry_s[j-1] >= sh[pgku_pkg::NUM_W-1:0]);
			rx_n[j] = gex_n[j] ? dv_rx_s[j-1] - sh[pgku_pkg::NUM_W-1:0] : dv_rx_s[j-1];
			ry_n[j] = gey_n[j] ? dv_ry_s[j-1] - sh[pgku_pkg::NUM_W-1:0] : dv_ry_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_item_s[0].op     <= op_s6;
			dv_item_s[0].in_map <= in_map_s6;
			dv_item_s[0].upd    <= (op_s6 == pgku_pkg::OP_UPDATE) && big_s6 && (s_s6 > 0);
			dv_item_s[0].est    <= cell_s6;
			dv_item_s[0].nu     <= nu_s6;
			dv_item_s[0].pvx    <= pvx_s6;
			dv_item_s[0].pvy    <= pvy_s6;
			dv_d_s[0]  <= (s_s6 > 0) ? s_s6[pgku_pkg::DIV_W-1:0] : pgku_pkg::DIV_W'(1);
			dv_rx_s[0] <= {pgku_pkg::abs32(pvx_s6), pgku_pkg::NUM_LO'(0)};
			dv_ry_s[0] <= {pgku_pkg::abs32(pvy_s6), pgku_pkg::NUM_LO'(0)};
			dv_qx_s[0] <= '0;
			dv_qy_s[0] <= '0;
			dv_ox_s[0] <= 1'b0;
			dv_oy_s[0] <= 1'b0;
			dv_nx_s[0] <= pvx_s6[pgku_pkg::VAL_W-1];
			dv_ny_s[0] <= pvy_s6[pgku_pkg::VAL_W-1];

			dv_item_s[1] <= dv_item_s[0];
			dv_d_s[1]    <= dv_d_s[0];
			dv_rx_s[1]   <= dv_rx_s[0];
			dv_ry_s[1]   <= dv_ry_s[0];
			dv_qx_s[1]   <= '0;
			dv_qy_s[1]   <= '0;
			dv_ox_s[1]   <= (dv_d_s[0][pgku_pkg::DIV_W-1:pgku_pkg::NUM_LO] == '0) &&
					(dv_rx_s[0] >= {dv_d_s[0][pgku_pkg::NUM_LO-1:0], pgku_pkg::QUO_W'(0)});
			dv_oy_s[1]   <= (dv_d_s[0][pgku_pkg::DIV_W-1:pgku_pkg::NUM_LO] == '0) &&
					(dv_ry_s[0] >= {dv_d_s[0][pgku_pkg::NUM_LO-1:0], pgku_pkg::QUO_W'(0)});
			dv_nx_s[1]   <= dv_nx_s[0];
			dv_ny_s[1]   <= dv_ny_s[0];

			for (int j = 2; j < pgku_pkg::DIV_STAGES; j++) begin
				dv_item_s[j] <= dv_item_s[j-1];
				dv_d_s[j]    <= dv_d_s[j-1];
				dv_rx_s[j]   <= rx_n[j];
				dv_ry_s[j]   <= ry_n[j];
				dv_qx_s[j]   <= {dv_qx_s[j-1][pgku_pkg::QUO_W-2:0], gex_n[j]};
				dv_qy_s[j]   <= {dv_qy_s[j-1][pgku_pkg::QUO_W-2:0], gey_n[j]};
				dv_ox_s[j]   <= dv_ox_s[j-1];
				dv_oy_s[j]   <= dv_oy_s[j-1];
				dv_nx_s[j]   <= dv_nx_s[j-1];
				dv_ny_s[j]   <= dv_ny_s[j-1];
			end
		end
	end

	// gain saturation, corrections, rounding
	always_ff @(posedge clk) begin
		if (en) begin
			item_s41 <= dv_item_s[pgku_pkg::DIV_STAGES-1];
			wx_s41   <= pgku_pkg::wsat(dv_qx_s[pgku_pkg::DIV_STAGES-1],
					dv_ox_s[pgku_pkg::DIV_STAGES-1], dv_nx_s[pgku_pkg::DIV_STAGES-1]);
			wy_s41   <= pgku_pkg::wsat(dv_qy_s[pgku_pkg::DIV_STAGES-1],
					dv_oy_s[pgku_pkg::DIV_STAGES-1], dv_ny_s[pgku_pkg::DIV_STAGES-1]);

			item_s42 <= item_s41;
			wxnu_s42 <= wx_s41 * $signed(item_s41.nu);
			wynu_s42 <= wy_s41 * $signed(item_s41.nu);
			wxpx_s42 <= wx_s41 * $signed(item_s41.pvx);
			wypy_s42 <= wy_s41 * $signed(item_s41.pvy);
			wxpy_s42 <= wx_s41 * $signed(item_s41.pvy);

			item_s43 <= item_s42;
			rgx_s43  <= pgku_pkg::RG_W'(pgku_pkg::rnd(wxnu_s42, 14));
			rgy_s43  <= pgku_pkg::RG_W'(pgku_pkg::rnd(wynu_s42, 14));
			rva_s43  <= pgku_pkg::RV_W'(pgku_pkg::rnd(wxpx_s42, 16));
			rvb_s43  <= pgku_pkg::RV_W'(pgku_pkg::rnd(wypy_s42, 16));
			rvc_s43  <= pgku_pkg::RV_W'(pgku_pkg::rnd(wxpy_s42, 16));
		end
	end

	// write back
	always_comb begin
		cell_new = item_s43.est;
		if (item_s43.op == pgku_pkg::OP_CLEAR) begin
			cell_new.gx = '0;
			cell_new.gy = '0;
			cell_new.a  = init_var_q;
			cell_new.b  = init_var_q;
			cell_new.c  = '0;
		end else if (item_s43.upd) begin
			cell_new.gx = pgku_pkg::sat32(64'($signed(item_s43.est.gx)) + 64'(rgx_s43));
			cell_new.gy = pgku_pkg::sat32(64'($signed(item_s43.est.gy)) + 64'(rgy_s43));
			cell_new.a  = pgku_pkg::satu32($signed(64'(item_s43.est.a)) - 64'(rva_s43));
			cell_new.b  = pgku_pkg::satu32($signed(64'(item_s43.est.b)) - 64'(rvb_s43));
			cell_new.c  = pgku_pkg::sat32(64'($signed(item_s43.est.c)) - 64'(rvc_s43));
		end
	end

	assign ram_we = en && tag_v_s[pgku_pkg::NST] && item_s43.in_map &&
			(item_s43.op == pgku_pkg::OP_CLEAR || item_s43.upd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (en)
			out_v_q <= tag_v_s[pgku_pkg::NST];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grad_x_q  <= item_s43.in_map ? cell_new.gx : '0;
			grad_y_q  <= item_s43.in_map ? cell_new.gy : '0;
			var_x_q   <= item_s43.in_map ? cell_new.a : '0;
			var_y_q   <= item_s43.in_map ? cell_new.b : '0;
			applied_q <= item_s43.in_map && item_s43.upd;
		end
	end

	assign out_valid = out_v_q;
	assign grad_x    = grad_x_q;
	assign grad_y    = grad_y_q;
	assign var_x     = var_x_q;
	assign var_y     = var_y_q;
	assign applied   = applied_q;

`ifndef SYNTHESIS
	a_we_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> tag_v_s[pgku_pkg::NST] && item_s43.in_map)
		else $error("write back of a transaction outside the map");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(tag_v_s))
		else $error("pipeline advanced while held");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> tag_v_s[1] && tag_addr_s[1] == $past(in_addr))
		else $error("accepted transaction missing from first stage");

	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !(tag_v_s[1] && tag_addr_s[1] == tag_addr_s[pgku_pkg::NST]))
		else $error("two transactions on one pixel in flight");
`endif

endmodule
`default_nettype wire

[dv/pixel_gradient_kalman_update_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_gradient_kalman_update_tb
// Self-checking bench for the per-pixel gradient Kalman update. A tracker
// class keeps its own copy of every cleared pixel, predicts each result in
// fixed point and checks the results in order. Directed corner cases run
// first, then random clear/update sequences on a small set of live pixels
// under several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module pixel_gradient_kalman_update_tb;

	typedef struct {
		pgku_pkg::op_t                      op;
		logic [pgku_pkg::COORD_W-1:0]       px;
		logic [pgku_pkg::COORD_W-1:0]       py;
		logic signed [pgku_pkg::MEAS_W-1:0] meas;
		logic signed [pgku_pkg::VEL_W-1:0]  vx;
		logic signed [pgku_pkg::VEL_W-1:0]  vy;
	} pix_item_t;

	typedef struct {
		logic signed [pgku_pkg::VAL_W-1:0] gx;
		logic signed [pgku_pkg::VAL_W-1:0] gy;
		logic [pgku_pkg::VAL_W-1:0]        vxx;
		logic [pgku_pkg::VAL_W-1:0]        vyy;
		logic                              applied;
	} pix_result_t;

	class kalman_tracker;
		longint gx_map[int], gy_map[int], a_map[int], b_map[int], c_map[int];
		longint noise, init_var, thr;
		pix_result_t expected_results[$];
		int errors;

		function new();
			noise = 65536; init_var = 65536; thr = 2; errors = 0;
		endfunction

		function longint rsh(longint x, int k);
			return (x + (longint'(1) <<< (k - 1))) >>> k;
		endfunction

		function longint sat_s(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		function longint sat_u(longint x);
			if (x < 0) return 0;
			if (x > 64'sd4294967295) return 64'sd4294967295;
			return x;
		endfunction

		function void set_reg(pgku_pkg::cfg_reg_t idx, logic [31:0] v);
			case (idx)
				pgku_pkg::REG_MEAS_NOISE:    noise = longint'(v);
				pgku_pkg::REG_INIT_VARIANCE: init_var = longint'(v);
				pgku_pkg::REG_MIN_MEAS:      thr = longint'(v & 32'h7fffff);
				default: ;
			endcase
		endfunction

		function void note_item(pix_item_t it);
			int p;
			longint m, vx, vy, mag, gx, gy, a, b, c, h, nu, pvx, pvy, s, wx, wy;
			pix_result_t r;
			p = int'({it.py, it.px});
			r.applied = 1'b0;
			if (it.op == pgku_pkg::OP_CLEAR) begin
				gx_map[p] = 0; gy_map[p] = 0; a_map[p] = init_var; b_map[p] = init_var;
				c_map[p] = 0;
			end else begin
				m = longint'(it.meas); vx = longint'(it.vx); vy = longint'(it.vy);
				mag = m < 0 ? -m : m;
				if (mag >= thr) begin
					gx = gx_map[p]; gy = gy_map[p]; a = a_map[p]; b = b_map[p]; c = c_map[p];
					h = rsh(gx * vx + gy * vy, 14);
					nu = sat_s(m - h);
					pvx = sat_s(rsh(a * vx + c * vy, 12));
					pvy = sat_s(rsh(c * vx + b * vy, 12));
					s = vx * pvx + vy * pvy + (noise <<< 12);
					if (s > 0) begin
						wx = sat_s((pvx <<< 28) / s);
						wy = sat_s((pvy <<< 28) / s);
						gx_map[p] = sat_s(gx + rsh(wx * nu, 14));
						gy_map[p] = sat_s(gy + rsh(wy * nu, 14));
						a_map[p] = sat_u(a - rsh(wx * pvx, 16));
						b_map[p] = sat_u(b - rsh(wy * pvy, 16));
						c_map[p] = sat_s(c - rsh(wx * pvy, 16));
						r.applied = 1'b1;
					end
				end
			end
			r.gx = gx_map[p][31:0]; r.gy = gy_map[p][31:0];
			r.vxx = a_map[p][31:0]; r.vyy = b_map[p][31:0];
			expected_results = {expected_results, r};
		endfunction

		function void check_result(pix_result_t got);
			pix_result_t e;
			if (expected_results.size() == 0) begin
				$error("result with no transaction pending");
				errors++;
				return;
			end
			e = expected_results.pop_front();
			if (got.gx !== e.gx) begin
				$error("grad_x expected %0d actual %0d", e.gx, got.gx); errors++;
			end
			if (got.gy !== e.gy) begin
				$error("grad_y expected %0d actual %0d", e.gy, got.gy); errors++;
			end
			if (got.vxx !== e.vxx) begin
				$error("var_x expected %0d actual %0d", e.vxx, got.vxx); errors++;
			end
			if (got.vyy !== e.vyy) begin
				$error("var_y expected %0d actual %0d", e.vyy, got.vyy); errors++;
			end
			if (got.applied !== e.applied) begin
				$error("applied expected %0b actual %0b", e.applied, got.applied); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [pgku_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pgku_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = 1'b0;
	logic [pgku_pkg::COORD_W-1:0] pixel_x = '0, pixel_y = '0;
	logic signed [pgku_pkg::MEAS_W-1:0] meas = '0;
	logic signed [pgku_pkg::VEL_W-1:0] vel_x = '0, vel_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [pgku_pkg::VAL_W-1:0] grad_x, grad_y;
	logic [pgku_pkg::VAL_W-1:0] var_x, var_y;
	logic applied;

	kalman_tracker tracker = new();
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int live_pixels[$];

	pixel_gradient_kalman_update dut (.*);

	always #2 clk = ~clk;

	initial begin
		#10_000_000;
		$display("pixel_gradient_kalman_update regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		pix_result_t got;
		if (out_valid && !out_stall) begin
			got.gx = grad_x; got.gy = grad_y; got.vxx = var_x; got.vyy = var_y;
			got.applied = applied;
			tracker.check_result(got);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send(pix_item_t it);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op; pixel_x <= it.px; pixel_y <= it.py;
		meas <= it.meas; vel_x <= it.vx; vel_y <= it.vy;
		do @(posedge clk); while (in_stall);
		tracker.note_item(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.expected_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(pgku_pkg::cfg_reg_t idx, logic [31:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		tracker.set_reg(idx, v);
	endtask

	task automatic direct(pgku_pkg::op_t o, int x, int y, int m, int vx, int vy);
		pix_item_t it;
		it.op = o; it.px = x[7:0]; it.py = y[7:0];
		it.meas = m[23:0]; it.vx = vx[23:0]; it.vy = vy[23:0];
		send(it);
	endtask

	function automatic logic signed [pgku_pkg::VEL_W-1:0] pick_vel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return pgku_pkg::VEL_W'($urandom);
			2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
			default: return pgku_pkg::VEL_W'($urandom_range(0, 32767)) - 24'sd16384;
		endcase
	endfunction

	function automatic logic signed [pgku_pkg::MEAS_W-1:0] pick_meas();
		case ($urandom_range(0, 7))
			0, 1: return pgku_pkg::MEAS_W'($urandom);
			2: return pgku_pkg::MEAS_W'($urandom_range(0, 6)) - 24'sd3;
			3: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
			default: return pgku_pkg::MEAS_W'($urandom_range(0, 65535)) - 24'sd32768;
		endcase
	endfunction

	function automatic logic [31:0] pick_cfg();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'hffffffff;
			2: return $urandom;
			default: return $urandom_range(1, 1 << 20);
		endcase
	endfunction

	task automatic random_items(int count);
		pix_item_t it;
		int p;
		for (int i = 0; i < count; i++) begin
			it.meas = pick_meas(); it.vx = pick_vel(); it.vy = pick_vel();
			if (live_pixels.size() == 0 || $urandom_range(0, 99) < 15) begin
				it.op = pgku_pkg::OP_CLEAR;
				p = $urandom_range(0, pgku_pkg::PIXELS - 1);
				live_pixels = {live_pixels, p};
				if (live_pixels.size() > 16) void'(live_pixels.pop_front());
			end else begin
				it.op = pgku_pkg::OP_UPDATE;
				p = live_pixels[$urandom_range(0, live_pixels.size() - 1)];
			end
			it.px = p[7:0]; it.py = p[15:8];
			send(it);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		direct(pgku_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
		direct(pgku_pkg::OP_CLEAR, 255, 255, -1, -1, -1);
		direct(pgku_pkg::OP_CLEAR, 17, 200, 5, 5, 5);
		direct(pgku_pkg::OP_UPDATE, 0, 0, 8388607, 8388607, 8388607);
		direct(pgku_pkg::OP_UPDATE, 255, 255, -8388608, -8388608, -8388608);
		direct(pgku_pkg::OP_UPDATE, 0, 0, 1, 4096, 4096);
		direct(pgku_pkg::OP_UPDATE, 0, 0, -2, 4096, -4096);
		direct(pgku_pkg::OP_UPDATE, 17, 200, 16384, 0, 0);
		direct(pgku_pkg::OP_UPDATE, 17, 200, -16384, 8388607, -8388608);
		direct(pgku_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
		drain();

		write_reg(pgku_pkg::REG_MEAS_NOISE, 32'd0);
		write_reg(pgku_pkg::REG_INIT_VARIANCE, 32'hffffffff);
		write_reg(pgku_pkg::REG_MIN_MEAS, 32'd0);
		direct(pgku_pkg::OP_CLEAR, 5, 5, 0, 0, 0);
		direct(pgku_pkg::OP_UPDATE, 5, 5, 16384, 0, 0);
		direct(pgku_pkg::OP_UPDATE, 5, 5, 0, 4096, 0);
		direct(pgku_pkg::OP_UPDATE, 5, 5, 8388607, 8388607, -8388608);
		drain();

		write_reg(pgku_pkg::REG_INIT_VARIANCE, 32'd0);
		direct(pgku_pkg::OP_CLEAR, 9, 9, 0, 0, 0);
		direct(pgku_pkg::OP_UPDATE, 9, 9, 16384, 4096, 4096);
		drain();

		write_reg(pgku_pkg::REG_MEAS_NOISE, 32'hffffffff);
		write_reg(pgku_pkg::REG_INIT_VARIANCE, 32'd65536);
		write_reg(pgku_pkg::REG_MIN_MEAS, 32'h7fffff);
		direct(pgku_pkg::OP_CLEAR, 1, 254, 0, 0, 0);
		direct(pgku_pkg::OP_UPDATE, 1, 254, 8388606, 4096, 4096);
		direct(pgku_pkg::OP_UPDATE, 1, 254, 8388607, 4096, 4096);
		direct(pgku_pkg::OP_UPDATE, 1, 254, -8388608, -4096, 4096);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(pgku_pkg::REG_MEAS_NOISE, pick_cfg());
			write_reg(pgku_pkg::REG_INIT_VARIANCE, pick_cfg());
			write_reg(pgku_pkg::REG_MIN_MEAS, $urandom_range(0, 3) == 0 ? pick_cfg() :
				32'($urandom_range(0, 64)));
			if (ph == 3) quiet = 1'b1;
			if (ph == 1) begin
				random_items(20);
				hold_req = 1'b1;
				random_items(105);
			end else begin
				random_items(125);
			end
			drain();
		end

		if (tracker.errors == 0)
			$display("pixel_gradient_kalman_update regression: pass");
		else
			$display("pixel_gradient_kalman_update regression: fail");
		$finish;
	end

endmodule

[files.f]
src/pgku_pkg.sv
src/pgku_ram.sv
src/pixel_gradient_kalman_update.sv
dv/pixel_gradient_kalman_update_tb.sv
